// ===== hdl/tsp_pkg.sv =====
// Shared types and constants for the trapezoidal speed profile block.
// Holds the channel words, request and register codes, and the
// command and status words between controller and datapath.
package tsp_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_MOVE  = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_ESTOP = 2'd3
	} req_t;

	localparam logic [2:0] CFG_ACCEL      = 3'd0;
	localparam logic [2:0] CFG_DECEL      = 3'd1;
	localparam logic [2:0] CFG_EDECEL     = 3'd2;
	localparam logic [2:0] CFG_MAX_SPEED  = 3'd3;
	localparam logic [2:0] CFG_PERIOD     = 3'd4;
	localparam logic [2:0] CFG_STEP_LEN   = 3'd5;

	localparam logic [30:0] RST_ACCEL     = 31'd1677722;
	localparam logic [30:0] RST_DECEL     = 31'd1677722;
	localparam logic [30:0] RST_EDECEL    = 31'd3355443;
	localparam logic [30:0] RST_MAX_SPEED = 31'd2516582;
	localparam logic [24:0] RST_PERIOD    = 25'd167772;
	localparam logic [31:0] RST_STEP_LEN  = 32'd4295;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] position_steps;
		logic signed [31:0] move_distance;
		logic signed [31:0] end_speed;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] speed;
		logic               moving;
		logic               emergency_active;
	} out_word_t;

	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_POS  = 3'd1,
		MUL_VV   = 3'd2,
		MUL_FF   = 3'd3,
		MUL_STEP = 3'd4
	} mul_sel_t;

	typedef struct packed {
		logic     ld_in;
		mul_sel_t mul_sel;
		logic     ld_pos;
		logic     ld_rem;
		logic     ld_mag;
		logic     div_start;
		logic     dec_tick;
		logic     apply_stop;
		logic     apply_step;
		logic     apply_move;
		logic     ld_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       active;
		logic       end_move;
		logic       div_done;
	} dp_status_t;

endpackage

// ===== hdl/tsp_div.sv =====
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed 64-bit dividend, unsigned nonzero 32-bit divisor. Uses no package.
module tsp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic [31:0]        den,
	output logic               done,
	output logic signed [63:0] quo
);
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] dq_q;
	logic [31:0] den_q;
	logic [32:0] sh;
	logic        ge;

	assign sh = {rem_q, dq_q[63]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63];
			dq_q  <= num[63] ? 64'(-num) : 64'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(sh - {1'b0, den_q}) : sh[31:0];
			dq_q  <= {dq_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(dq_q) : $signed(dq_q);
endmodule

// ===== hdl/tsp_dp.sv =====
// Datapath: configuration registers, profile state, shared multiplier,
// wide adders and output register. Depends on tsp_pkg and tsp_div.
module tsp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tsp_pkg::dp_cmd_t    cmd,
	output tsp_pkg::dp_status_t status,
	input  tsp_pkg::in_word_t   in_data,
	output tsp_pkg::out_word_t  out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import tsp_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	logic [30:0] acc_q, dec_q, edec_q, max_q;
	logic [24:0] per_q;
	logic [31:0] step_len_q;

	logic               active_q, eflag_q, dir_q;
	logic signed [31:0] goal_q, gspeed_q, speed_q;

	in_word_t           in_q;
	out_word_t          out_q;
	logic signed [65:0] prod_q;
	logic signed [63:0] p_q, rem_q, vv_q, mag_q;
	logic               up_q, go_q;

	logic signed [32:0] mul_a, mul_b;
	logic [30:0]        step_sel, den_sel;
	logic [31:0]        den;
	logic signed [63:0] div_num, quo;
	logic               div_done;
	logic               is_tick;
	logic [32:0]        av;
	logic signed [63:0] stop_dist, move_dist;
	logic signed [33:0] v34, d34, nv;

	assign is_tick = in_q.req_type == REQ_TICK;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_NONE: begin
			end
			MUL_POS: begin
				mul_a = {in_q.position_steps[31], in_q.position_steps};
				mul_b = {1'b0, step_len_q};
			end
			MUL_VV: begin
				mul_a = {speed_q[31], speed_q};
				mul_b = {speed_q[31], speed_q};
			end
			MUL_FF: begin
				if (is_tick) begin
					mul_a = {gspeed_q[31], gspeed_q};
					mul_b = {gspeed_q[31], gspeed_q};
				end
			end
			MUL_STEP: begin
				mul_a = {2'b00, step_sel};
				mul_b = {8'd0, per_q};
			end
			default: begin
			end
		endcase
	end

	assign step_sel = up_q ? acc_q : (eflag_q ? edec_q : dec_q);
	assign den_sel  = (in_q.req_type == REQ_ESTOP) ? edec_q : dec_q;
	assign den      = (den_sel == 31'd0) ? 32'd2 : {den_sel, 1'b0};
	assign div_num  = vv_q - prod_q[63:0];

	tsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	assign av        = speed_q[31] ? (33'd0 - {speed_q[31], speed_q}) : {1'b0, speed_q};
	assign stop_dist = dir_q ? -quo : quo;
	assign move_dist = 64'(in_q.move_distance);
	assign v34       = 34'(speed_q);
	assign d34       = {2'b00, prod_q[55:24]};
	// up and negative, or down and positive: subtract
	assign nv        = (up_q == rem_q[63]) ? v34 - d34 : v34 + d34;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= RST_ACCEL;
			dec_q      <= RST_DECEL;
			edec_q     <= RST_EDECEL;
			max_q      <= RST_MAX_SPEED;
			per_q      <= RST_PERIOD;
			step_len_q <= RST_STEP_LEN;
			active_q   <= 1'b0;
			eflag_q    <= 1'b0;
			dir_q      <= 1'b0;
			goal_q     <= '0;
			gspeed_q   <= '0;
			speed_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ACCEL:     acc_q      <= cfg_data[30:0];
					CFG_DECEL:     dec_q      <= cfg_data[30:0];
					CFG_EDECEL:    edec_q     <= cfg_data[30:0];
					CFG_MAX_SPEED: max_q      <= cfg_data[30:0];
					CFG_PERIOD:    per_q      <= cfg_data[24:0];
					CFG_STEP_LEN:  step_len_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.dec_tick && status.end_move) begin
				active_q <= 1'b0;
				if (gspeed_q == 32'sd0)
					speed_q <= '0;
			end
			if (cmd.apply_stop) begin
				eflag_q <= in_q.req_type == REQ_ESTOP;
				if (quo == 64'sd0) begin
					active_q <= 1'b0;
				end else begin
					goal_q   <= sat32(stop_dist + p_q);
					gspeed_q <= '0;
					active_q <= 1'b1;
				end
			end
			if (cmd.apply_step && go_q)
				speed_q <= sat32(64'(nv));
			if (cmd.apply_move) begin
				eflag_q <= 1'b0;
				if (move_dist == 64'sd0) begin
					active_q <= 1'b0;
				end else begin
					goal_q   <= sat32(move_dist + p_q);
					gspeed_q <= in_q.end_speed;
					active_q <= 1'b1;
					dir_q    <= move_dist[63];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in)
			in_q <= in_data;
		prod_q <= mul_a * mul_b;
		if (cmd.ld_pos)
			p_q <= $signed(prod_q[63:0]) >>> 8;
		if (cmd.ld_rem)
			rem_q <= 64'(goal_q) - p_q;
		if (cmd.ld_mag) begin
			vv_q  <= prod_q[63:0];
			mag_q <= rem_q[63] ? -rem_q : rem_q;
		end
		if (cmd.dec_tick) begin
			up_q <= mag_q > quo;
			go_q <= (mag_q > quo) ? (av < {2'b00, max_q}) : 1'b1;
		end
		if (cmd.ld_out) begin
			out_q.speed            <= speed_q;
			out_q.moving           <= active_q;
			out_q.emergency_active <= active_q & eflag_q;
		end
	end

	assign status.req      = in_q.req_type;
	assign status.active   = active_q;
	assign status.end_move = rem_q[63] != dir_q;
	assign status.div_done = div_done;
	assign out_data        = out_q;
endmodule

// ===== hdl/tsp_ctrl.sv =====
// Sequencer for the profile datapath: steps one item through multiply,
// divide and update phases. Depends on tsp_pkg.
module tsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  tsp_pkg::dp_status_t status,
	output tsp_pkg::dp_cmd_t    cmd
);
	import tsp_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_POS  = 12'b0000_0000_0010,
		ST_POSL = 12'b0000_0000_0100,
		ST_VV   = 12'b0000_0000_1000,
		ST_FF   = 12'b0000_0001_0000,
		ST_DIVS = 12'b0000_0010_0000,
		ST_DIVW = 12'b0000_0100_0000,
		ST_DEC  = 12'b0000_1000_0000,
		ST_MULS = 12'b0001_0000_0000,
		ST_STEP = 12'b0010_0000_0000,
		ST_MOVE = 12'b0100_0000_0000,
		ST_DONE = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   is_tick;

	assign out_free = !out_valid_q || !out_stall;
	assign is_tick  = status.req == REQ_TICK;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ld_in = in_valid;
				if (in_valid)
					state_d = ST_POS;
			end
			ST_POS: begin
				cmd.mul_sel = MUL_POS;
				state_d     = ST_POSL;
			end
			ST_POSL: begin
				cmd.ld_pos = 1'b1;
				priority if (status.req == REQ_MOVE)
					state_d = ST_MOVE;
				else if (is_tick && !status.active)
					state_d = ST_DONE;
				else
					state_d = ST_VV;
			end
			ST_VV: begin
				cmd.mul_sel = MUL_VV;
				cmd.ld_rem  = 1'b1;
				state_d     = ST_FF;
			end
			ST_FF: begin
				cmd.mul_sel = MUL_FF;
				cmd.ld_mag  = 1'b1;
				state_d     = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (status.div_done)
					state_d = ST_DEC;
			end
			ST_DEC: begin
				if (is_tick) begin
					cmd.dec_tick = 1'b1;
					state_d      = status.end_move ? ST_DONE : ST_MULS;
				end else begin
					cmd.apply_stop = 1'b1;
					state_d        = ST_DONE;
				end
			end
			ST_MULS: begin
				cmd.mul_sel = MUL_STEP;
				state_d     = ST_STEP;
			end
			ST_STEP: begin
				cmd.apply_step = 1'b1;
				state_d        = ST_DONE;
			end
			ST_MOVE: begin
				cmd.apply_move = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the word
				cmd.ld_out = out_free;
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
endmodule

// ===== hdl/trapezoidal_speed_profile.sv =====
// Trapezoidal speed profile generator, signed Q8.24, one result word per input word.
// A tick while idle and a move skip the divider; a stop and a tick while moving wait
// on the serial divider. A new word is taken only after the last result is loaded into
// the output register, and out_stall can hold that load back.
// Reset clears registers to defaults and the profile state to idle at zero speed.
module trapezoidal_speed_profile (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tsp_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tsp_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import tsp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	tsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule

// ===== sim/tb_trapezoidal_speed_profile.sv =====
`timescale 1ns / 100ps
// Testbench for the trapezoidal speed profile block: drives request words,
// predicts each result word with a local profile model and checks it.
// Depends on tsp_pkg and the trapezoidal_speed_profile top level.
module tb_trapezoidal_speed_profile;
	import tsp_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	out_word_t expected_words[$];

	// profile state and registers mirrored from the block
	logic [30:0] p_acc, p_dec, p_edec, p_vmax;
	logic [24:0] p_period;
	logic [31:0] p_step_len;
	logic p_active, p_emerg, p_dir_neg;
	logic signed [31:0] p_goal, p_goal_speed, p_speed;

	trapezoidal_speed_profile u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint nz_dec(logic [30:0] d);
		return (d == 0) ? 64'sd1 : longint'({33'd0, d});
	endfunction

	function automatic longint rate_step(logic [30:0] a);
		logic [63:0] prod;
		prod = {33'd0, a} * {39'd0, p_period};
		return longint'(prod >> 24);
	endfunction

	function automatic void reset_profile();
		p_acc = RST_ACCEL; p_dec = RST_DECEL; p_edec = RST_EDECEL;
		p_vmax = RST_MAX_SPEED; p_period = RST_PERIOD; p_step_len = RST_STEP_LEN;
		p_active = 0; p_emerg = 0; p_dir_neg = 0;
		p_goal = 0; p_goal_speed = 0; p_speed = 0;
	endfunction

	function automatic void apply_goal(longint dist_q, longint pos, logic signed [31:0] fs);
		if (dist_q == 0) begin
			p_active = 0;
			p_emerg = 0;
			return;
		end
		p_goal = 32'(sat32(dist_q + pos));
		p_goal_speed = fs;
		p_active = 1;
		p_emerg = 0;
		p_dir_neg = dist_q < 0;
	endfunction

	function automatic out_word_t profile_step(in_word_t w);
		longint pos, v, f, rem, brake, mag, nv, d;
		logic neg;
		out_word_t r;
		pos = (longint'(w.position_steps) * longint'({32'd0, p_step_len})) >>> 8;
		case (req_t'(w.req_type))
			REQ_TICK: if (p_active) begin
				v = p_speed;
				f = p_goal_speed;
				rem = longint'(p_goal) - pos;
				neg = rem < 0;
				if (neg != p_dir_neg) begin
					p_active = 0;
					if (p_goal_speed == 0) p_speed = 0;
				end else begin
					brake = (v * v - f * f) / (2 * nz_dec(p_dec));
					mag = neg ? -rem : rem;
					nv = v;
					if (mag > brake) begin
						if ((v < 0 ? -v : v) < longint'({33'd0, p_vmax})) begin
							d = rate_step(p_acc);
							nv = neg ? v - d : v + d;
						end
					end else begin
						d = rate_step(p_emerg ? p_edec : p_dec);
						nv = neg ? v + d : v - d;
					end
					p_speed = 32'(sat32(nv));
				end
			end
			REQ_MOVE: apply_goal(longint'(w.move_distance), pos, w.end_speed);
			default: begin
				v = p_speed;
				d = (v * v) / (2 * nz_dec((w.req_type == REQ_ESTOP) ? p_edec : p_dec));
				apply_goal(p_dir_neg ? -d : d, pos, 0);
				p_emerg = (w.req_type == REQ_ESTOP);
			end
		endcase
		r.speed = p_speed;
		r.moving = p_active;
		r.emergency_active = p_active & p_emerg;
		return r;
	endfunction

	// sample results at the rising edge, change stall at the falling edge
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, out_data);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (out_data.speed !== e.speed) begin
					$display("%0t: speed exp %0d got %0d", $time, e.speed, out_data.speed);
					errors++;
				end
				if (out_data.moving !== e.moving) begin
					$display("%0t: moving exp %0b got %0b", $time, e.moving,
						out_data.moving);
					errors++;
				end
				if (out_data.emergency_active !== e.emergency_active) begin
					$display("%0t: emergency exp %0b got %0b", $time,
						e.emergency_active, out_data.emergency_active);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		in_data = w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_words.push_back(profile_step(w));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_req(req_t r, logic signed [31:0] pos, logic signed [31:0] dist_q,
			logic signed [31:0] fs);
		in_word_t w;
		w.req_type = r;
		w.position_steps = pos;
		w.move_distance = dist_q;
		w.end_speed = fs;
		send_word(w);
	endtask

	task automatic wait_drained();
		while (expected_words.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ACCEL:     p_acc = val[30:0];
			CFG_DECEL:     p_dec = val[30:0];
			CFG_EDECEL:    p_edec = val[30:0];
			CFG_MAX_SPEED: p_vmax = val[30:0];
			CFG_PERIOD:    p_period = val[24:0];
			CFG_STEP_LEN:  p_step_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_directed();
		send_req(REQ_TICK, 0, 0, 0);
		send_req(REQ_STOP, 0, 0, 0);
		send_req(REQ_MOVE, 0, 32'sd16777216, 0);
		repeat (6) send_req(REQ_TICK, 0, 0, 0);
		send_req(REQ_MOVE, 0, 0, 0);
		send_req(REQ_MOVE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_req(REQ_TICK, 32'sh7fffffff, 0, 0);
		send_req(REQ_MOVE, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		repeat (3) send_req(REQ_TICK, 32'sh80000000, 0, 0);
		send_req(REQ_ESTOP, 32'sh80000000, 0, 0);
		send_req(REQ_TICK, 32'sh80000000, 0, 0);
		send_req(REQ_TICK, 32'sh7fffffff, 0, 0);
		send_req(REQ_MOVE, 0, 32'sd1000, 32'sd5000);
		send_req(REQ_TICK, 0, 0, 0);
		send_req(REQ_TICK, 100, 0, 0);
		send_req(REQ_STOP, 0, 0, 0);
		send_req(REQ_ESTOP, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		wait_drained();
	endtask

	// mostly well-formed moves (a goal, a run of ticks with advancing position, some stops), some random words
	task automatic run_moves(int n);
		int sent;
		logic signed [31:0] pos, mv_dist, step;
		int ticks;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) == 0) begin
				send_req(req_t'($urandom_range(3)), $urandom, $urandom, $urandom);
				sent++;
				continue;
			end
			pos = $urandom_range(4000) - 2000;
			mv_dist = $urandom_range(1, 8) == 1 ? 32'($urandom)
				: 32'($urandom_range(33554432)) - 32'sd16777216;
			send_req(REQ_MOVE, pos, mv_dist,
				$urandom_range(3) == 0 ? 32'($urandom_range(500000)) : 0);
			sent++;
			ticks = $urandom_range(40, 5);
			step = mv_dist < 0 ? -32'($urandom_range(50000)) : 32'($urandom_range(50000));
			for (int k = 0; k < ticks && sent < n; k++) begin
				pos = pos + step;
				if ($urandom_range(19) == 0)
					send_req($urandom_range(1) ? REQ_STOP : REQ_ESTOP, pos, $urandom, $urandom);
				else
					send_req(REQ_TICK, pos, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	task automatic test_default_regs();
		send_idle_pct = 12; recv_stall_pct = 54;
		run_moves(350);
		// hold off until every result is back
		wait_drained();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_ACCEL, 32'h7fffffff);
		write_reg(CFG_DECEL, 32'd1);
		write_reg(CFG_EDECEL, 32'h7fffffff);
		write_reg(CFG_MAX_SPEED, 32'h7fffffff);
		write_reg(CFG_PERIOD, 32'd16777216);
		write_reg(CFG_STEP_LEN, 32'hffffffff);
		send_idle_pct = 54; recv_stall_pct = 12;
		run_moves(250);
		wait_drained();
		write_reg(CFG_ACCEL, 32'd0);
		write_reg(CFG_DECEL, 32'd0);
		write_reg(CFG_EDECEL, 32'd0);
		write_reg(CFG_MAX_SPEED, 32'd0);
		write_reg(CFG_PERIOD, 32'd1);
		write_reg(CFG_STEP_LEN, 32'd1);
		run_moves(150);
		wait_drained();
	endtask

	task automatic test_random_regs();
		send_idle_pct = 0; recv_stall_pct = 0;
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_ACCEL, $urandom_range(4000000));
			write_reg(CFG_DECEL, $urandom_range(4000000, 1));
			write_reg(CFG_EDECEL, $urandom_range(8000000, 1));
			write_reg(CFG_MAX_SPEED, $urandom_range(1) ? $urandom : $urandom_range(5000000));
			write_reg(CFG_PERIOD, $urandom_range(16777216, 1));
			write_reg(CFG_STEP_LEN, $urandom);
			run_moves(160);
			wait_drained();
		end
	endtask

	initial begin
		reset_profile();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_default_regs();
		test_register_extremes();
		test_random_regs();
		wait_drained();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== trapezoidal_speed_profile.f =====
hdl/tsp_pkg.sv
hdl/tsp_div.sv
hdl/tsp_dp.sv
hdl/tsp_ctrl.sv
hdl/trapezoidal_speed_profile.sv
sim/tb_trapezoidal_speed_profile.sv
